@@ rtl/lctf_pkg.sv @@
// Shared types and constants of the level crossing time fit block.
`timescale 1ns / 1ps
`default_nettype none
package lctf_pkg;

  localparam int VALUE_BITS = 16;
  localparam int WIDE_W     = 128;
  localparam int MB_W       = 40;

  localparam logic [2:0] CFG_LEVEL      = 3'd0;
  localparam logic [2:0] CFG_HALF       = 3'd1;
  localparam logic [2:0] CFG_BACKWARD   = 3'd2;
  localparam logic [2:0] CFG_TIME_MIN   = 3'd3;
  localparam logic [2:0] CFG_TIME_MAX   = 3'd4;
  localparam logic [2:0] CFG_MAX_OFFSET = 3'd5;

  typedef struct packed {
    logic [31:0]                  sample_time;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         last_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] crossing_time;
    logic        found;
  } out_item_t;

  typedef struct packed {
    logic [31:0]                  stamp;
    logic signed [VALUE_BITS-1:0] value;
  } win_t;

  typedef struct packed {
    logic win_shift;
    logic work_load;
    logic work_shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/lctf_cell.sv @@
// One cell of the sample chain: a window slot and a work slot.
`timescale 1ns / 1ps
`default_nettype none
module lctf_cell
  import lctf_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire win_t      win_in,
  input  wire win_t      work_in,
  output win_t           win,
  output win_t           work
);

  always_ff @(posedge clk) begin
    if (ctl.win_shift) begin
      win <= win_in;
    end
    if (ctl.work_load) begin
      work <= win;
    end else if (ctl.work_shift) begin
      work <= work_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lctf_mul.sv @@
// Shift-add multiplier, one bit of the narrow operand per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lctf_mul
  import lctf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [WIDE_W-1:0] a,
  input  wire logic signed [MB_W-1:0]   b,
  output logic                          done,
  output logic signed [WIDE_W-1:0]      p
);

  localparam int CW = $clog2(MB_W + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic              neg;
  logic [MB_W-1:0]   b_mag;
  logic [WIDE_W-1:0] a_sh;
  logic [WIDE_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(MB_W);
        acc   <= '0;
        a_sh  <= a;
        neg   <= b[MB_W-1];
        b_mag <= b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
      end else if (busy) begin
        if (cnt == '0) begin
          p    <= neg ? $signed(-acc) : $signed(acc);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          if (b_mag[0]) begin
            acc <= acc + a_sh;
          end
          a_sh  <= a_sh << 1;
          b_mag <= b_mag >> 1;
          cnt   <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/lctf_div.sv @@
// Restoring divider with floor rounding, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lctf_div
  import lctf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [WIDE_W-1:0] num,
  input  wire logic [WIDE_W-1:0]        den,
  output logic                          done,
  output logic signed [WIDE_W-1:0]      q
);

  localparam int CW = $clog2(WIDE_W + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic              neg;
  logic [WIDE_W-1:0] nmag;
  logic [WIDE_W-1:0] quo;
  logic [WIDE_W-1:0] dvs;
  logic [WIDE_W:0]   rem;
  logic [WIDE_W:0]   trial;

  assign trial = {rem[WIDE_W-1:0], nmag[WIDE_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDE_W);
        neg  <= num[WIDE_W-1];
        nmag <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
        dvs  <= den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        if (cnt == '0) begin
          if (!neg) begin
            q <= $signed(quo);
          end else if (rem != '0) begin
            q <= $signed(~quo);
          end else begin
            q <= $signed(-quo);
          end
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          if (trial >= {1'b0, dvs}) begin
            rem <= trial - {1'b0, dvs};
            quo <= {quo[WIDE_W-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[WIDE_W-2:0], 1'b0};
          end
          nmag <= nmag << 1;
          cnt  <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/level_crossing_time_fit.sv @@
// Top level of the level crossing time fit block.
//
//   channel  handshake                 payload
//   sample   sample_valid/sample_stall sample (in_item_t)
//   result   result_valid/result_stall result (out_item_t)
//   config   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A sample with no fit passes S_LOAD, S_SKIP (its length set by r = max(h,1)), S_CHECK and
// S_FINISH before the next sample is taken. A fit adds the accumulate pass, the products in the
// shared shift-add multiplier, the divider (skipped when the slope is zero), S_PREP and S_JUDGE.
// Reset is synchronous; no clearing pass. A result waiting on result_stall holds
// only the end of the next waveform; samples are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module level_crossing_time_fit
  import lctf_pkg::*;
#(
  parameter int MAX_HALF_WINDOW = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      sample_valid,
  output logic           sample_stall,
  input  wire in_item_t  sample,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_item_t      result,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
  localparam int LD     = $clog2(DEPTH);
  localparam int HW     = $clog2(MAX_HALF_WINDOW + 1);
  localparam int AW     = HW + 1;
  localparam int SX_W   = 34 + LD;
  localparam int SY_W   = VALUE_BITS + 1 + LD;
  localparam int PXY_W  = 33 + VALUE_BITS;
  localparam int SXY_W  = PXY_W + LD;
  localparam int SXX_W  = 66 + LD;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LOAD   = 10'b0000000010,
    S_SKIP   = 10'b0000000100,
    S_CHECK  = 10'b0000001000,
    S_ACC    = 10'b0000010000,
    S_MUL    = 10'b0000100000,
    S_PREP   = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_JUDGE  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    M_N_SXY, M_SX_SY, M_N_SXX, M_SX_SX, M_SY_SXX, M_SX_SXY, M_LVL_D
  } mul_step_t;

  state_t state;
  mul_step_t mstep;

  logic signed [VALUE_BITS-1:0] level;
  logic [3:0]  half_window;
  logic        search_backward;
  logic [31:0] time_min;
  logic [31:0] time_max;
  logic [31:0] max_offset;

  logic [15:0] samples_seen;
  logic [31:0] best_time;
  logic        have_crossing;
  logic        last_q;
  logic [HW-1:0] skip_cnt;
  logic [AW-1:0] acc_cnt;
  logic [31:0] tc;

  logic [HW-1:0] h;
  logic [HW-1:0] r;

  cell_ctl_t ctl;
  win_t      new_win;
  win_t      win_q  [DEPTH];
  win_t      work_q [DEPTH];

  logic signed [32:0]        dx;
  logic signed [32:0]        dx_r;
  logic signed [VALUE_BITS-1:0] v_r;
  logic signed [65:0]        p_xx;
  logic signed [PXY_W-1:0]   p_xy;
  logic                      pv;
  logic                      issue;
  logic signed [SX_W-1:0]    sx;
  logic signed [SY_W-1:0]    sy;
  logic signed [SXY_W-1:0]   sxy;
  logic signed [SXX_W-1:0]   sxx;

  logic signed [WIDE_W-1:0]  prod [7];
  logic signed [WIDE_W-1:0]  c_q;
  logic signed [WIDE_W-1:0]  num_q;
  logic signed [WIDE_W-1:0]  c_mag;
  logic signed [WIDE_W-1:0]  n_sgn;
  logic signed [WIDE_W-1:0]  off;
  logic signed [WIDE_W-1:0]  tabs;
  logic signed [WIDE_W-1:0]  aoff;

  logic                      mul_issued;
  logic                      mul_start;
  logic signed [WIDE_W-1:0]  mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic                      mul_done;
  logic signed [WIDE_W-1:0]  mul_p;

  logic                      div_issued;
  logic                      div_start;
  logic signed [WIDE_W-1:0]  div_num;
  logic [WIDE_W-1:0]         div_den;
  logic                      div_done;
  logic signed [WIDE_W-1:0]  div_q;

  logic eligible;
  logic cand;
  logic fit_go;
  logic load_out;
  logic fit_ok;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);

  assign h = (32'(half_window) > MAX_HALF_WINDOW) ? HW'(MAX_HALF_WINDOW) : HW'(half_window);
  assign r = (h == '0) ? HW'(1) : h;

  assign new_win.stamp = sample.sample_time;
  assign new_win.value = sample.sample_value;

  assign issue = (acc_cnt < {h, 1'b1});

  always_comb begin
    ctl.win_shift  = (state == S_IDLE) && sample_valid;
    ctl.work_load  = (state == S_LOAD) || ((state == S_CHECK) && fit_go);
    ctl.work_shift = ((state == S_SKIP) && (skip_cnt != '0)) || ((state == S_ACC) && issue);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    lctf_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .win_in  ((i == 0) ? new_win : win_q[(i == 0) ? 0 : i - 1]),
      .work_in ((i == DEPTH - 1) ? win_t'('0) : work_q[(i == DEPTH - 1) ? i : i + 1]),
      .win     (win_q[i]),
      .work    (work_q[i])
    );
  end

  always_comb begin
    eligible = (samples_seen >= 16'({r, 1'b1})) && !(!search_backward && have_crossing);
    if (search_backward) begin
      cand = (work_q[2].value > level) && (work_q[1].value > level) &&
             (work_q[0].value < level);
    end else begin
      cand = (work_q[2].value > level) && (work_q[1].value < level) &&
             (work_q[0].value < level);
    end
    fit_go = eligible && cand && (h != '0);
  end

  assign dx = $signed({1'b0, work_q[0].stamp}) - $signed({1'b0, tc});

  always_comb begin
    case (mstep)
      M_N_SXY:  begin mul_a = WIDE_W'(sxy); mul_b = $signed(MB_W'({h, 1'b1})); end
      M_SX_SY:  begin mul_a = WIDE_W'(sy);  mul_b = MB_W'(sx); end
      M_N_SXX:  begin mul_a = WIDE_W'(sxx); mul_b = $signed(MB_W'({h, 1'b1})); end
      M_SX_SX:  begin mul_a = WIDE_W'(sx);  mul_b = MB_W'(sx); end
      M_SY_SXX: begin mul_a = WIDE_W'(sxx); mul_b = MB_W'(sy); end
      M_SX_SXY: begin mul_a = WIDE_W'(sxy); mul_b = MB_W'(sx); end
      M_LVL_D:  begin mul_a = prod[M_N_SXX] - prod[M_SX_SX]; mul_b = MB_W'(level); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_start = (state == S_MUL) && !mul_issued;

  lctf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign c_mag     = c_q[WIDE_W-1] ? -c_q : c_q;
  assign n_sgn     = c_q[WIDE_W-1] ? -num_q : num_q;
  assign div_num   = (n_sgn <<< 1) + c_mag;
  assign div_den   = WIDE_W'(c_mag <<< 1);
  assign div_start = (state == S_DIV) && !div_issued && (c_q != '0);

  lctf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  assign tabs   = $signed({{(WIDE_W-32){1'b0}}, tc}) + off;
  assign aoff   = off[WIDE_W-1] ? -off : off;
  assign fit_ok = (tabs >= $signed({{(WIDE_W-32){1'b0}}, time_min})) &&
                  (tabs <= $signed({{(WIDE_W-32){1'b0}}, time_max})) &&
                  (aoff <= $signed({{(WIDE_W-32){1'b0}}, max_offset}));

  assign load_out = (state == S_FINISH) && last_q && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      level           <= '0;
      half_window     <= 4'd4;
      search_backward <= 1'b0;
      time_min        <= '0;
      time_max        <= '1;
      max_offset      <= 32'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEVEL:      level           <= cfg_data[VALUE_BITS-1:0];
        CFG_HALF:       half_window     <= cfg_data[3:0];
        CFG_BACKWARD:   search_backward <= cfg_data[0];
        CFG_TIME_MIN:   time_min        <= cfg_data;
        CFG_TIME_MAX:   time_max        <= cfg_data;
        CFG_MAX_OFFSET: max_offset      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ACC) begin
      p_xx <= dx * dx;
      p_xy <= dx * work_q[0].value;
      dx_r <= dx;
      v_r  <= work_q[0].value;
    end
    if ((state == S_CHECK) && fit_go) begin
      sx  <= '0;
      sy  <= '0;
      sxy <= '0;
      sxx <= '0;
    end else if ((state == S_ACC) && pv) begin
      sx  <= sx + SX_W'(dx_r);
      sy  <= sy + SY_W'(v_r);
      sxy <= sxy + SXY_W'(p_xy);
      sxx <= sxx + SXX_W'(p_xx);
    end
    if (mul_done) begin
      prod[mstep] <= mul_p;
    end
    if (state == S_PREP) begin
      c_q   <= prod[M_N_SXY] - prod[M_SX_SY];
      num_q <= prod[M_LVL_D] - prod[M_SY_SXX] + prod[M_SX_SXY];
    end
    if (div_done) begin
      off <= div_q;
    end
    if (load_out) begin
      result.crossing_time <= have_crossing ? best_time : 32'd0;
      result.found         <= have_crossing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mstep         <= M_N_SXY;
      samples_seen  <= '0;
      best_time     <= '0;
      have_crossing <= 1'b0;
      last_q        <= 1'b0;
      skip_cnt      <= '0;
      acc_cnt       <= '0;
      pv            <= 1'b0;
      mul_issued    <= 1'b0;
      div_issued    <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            if (samples_seen != 16'hFFFF) begin
              samples_seen <= samples_seen + 16'd1;
            end
            last_q <= sample.last_sample;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          skip_cnt <= r - 1'b1;
          state    <= S_SKIP;
        end
        S_SKIP: begin
          if (skip_cnt == '0) begin
            state <= S_CHECK;
          end else begin
            skip_cnt <= skip_cnt - 1'b1;
          end
        end
        S_CHECK: begin
          tc <= work_q[1].stamp;
          if (eligible && cand && (h == '0)) begin
            best_time     <= work_q[1].stamp;
            have_crossing <= 1'b1;
            state         <= S_FINISH;
          end else if (fit_go) begin
            acc_cnt <= '0;
            pv      <= 1'b0;
            state   <= S_ACC;
          end else begin
            state <= S_FINISH;
          end
        end
        S_ACC: begin
          pv <= issue;
          if (issue) begin
            acc_cnt <= acc_cnt + 1'b1;
          end else if (!pv) begin
            mstep      <= M_N_SXY;
            mul_issued <= 1'b0;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_start) begin
            mul_issued <= 1'b1;
          end
          if (mul_done) begin
            mul_issued <= 1'b0;
            if (mstep == M_LVL_D) begin
              state <= S_PREP;
            end else begin
              mstep <= mul_step_t'(mstep + 3'd1);
            end
          end
        end
        S_PREP: begin
          div_issued <= 1'b0;
          state      <= S_DIV;
        end
        S_DIV: begin
          if (c_q == '0) begin
            state <= S_FINISH;
          end else begin
            if (div_start) begin
              div_issued <= 1'b1;
            end
            if (div_done) begin
              div_issued <= 1'b0;
              state      <= S_JUDGE;
            end
          end
        end
        S_JUDGE: begin
          if (fit_ok) begin
            best_time     <= tabs[31:0];
            have_crossing <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (load_out) begin
            samples_seen  <= '0;
            best_time     <= '0;
            have_crossing <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/lctf_checker.sv @@
// Checker for the level crossing time fit block: predicts each result and compares it.
`timescale 1ns / 1ps
module lctf_checker
  import lctf_pkg::*;
#(
  parameter int MAX_HALF_WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  input  logic        sample_stall,
  input  in_item_t    sample,
  input  logic        result_valid,
  input  logic        result_stall,
  input  out_item_t   result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;

  typedef logic signed [127:0] wide_t;

  logic [31:0]                  ring_time [DEPTH];
  logic signed [VALUE_BITS-1:0] ring_val [DEPTH];
  int unsigned                  wr_pos;
  int unsigned                  seen;
  logic [31:0]                  best_time;
  bit                           have_cross;

  logic signed [VALUE_BITS-1:0] lvl;
  logic [3:0]                   half;
  bit                           backward;
  logic [31:0]                  tmin, tmax, maxoff;

  out_item_t crossing_q [$];

  function automatic int unsigned slot(int unsigned age);
    return (wr_pos + 2 * DEPTH - 1 - age) % DEPTH;
  endfunction

  function automatic wide_t floor_div(wide_t a, wide_t b);
    wide_t q;
    q = a / b;
    if ((a % b != 0) && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic bit fit_line(int unsigned h, output logic [31:0] t);
    wide_t sx, sy, sxy, sxx, nn, c, d, num, off, tabs, aoff, dx, v;
    logic [31:0] tc;
    int unsigned s;
    tc = ring_time[slot(h)];
    sx = 0; sy = 0; sxy = 0; sxx = 0;
    t = '0;
    nn = wide_t'(2 * h + 1);
    for (int unsigned a = 0; a <= 2 * h; a++) begin
      s = slot(a);
      dx = wide_t'({96'd0, ring_time[s]}) - wide_t'({96'd0, tc});
      v = wide_t'(ring_val[s]);
      sx = sx + dx;
      sy = sy + v;
      sxy = sxy + dx * v;
      sxx = sxx + dx * dx;
    end
    c = nn * sxy - sx * sy;
    if (c == 0) return 0;
    d = nn * sxx - sx * sx;
    num = wide_t'(lvl) * d - (sy * sxx - sx * sxy);
    if (c < 0) begin
      c = -c;
      num = -num;
    end
    off = floor_div(2 * num + c, 2 * c);
    tabs = wide_t'({96'd0, tc}) + off;
    if (tabs < wide_t'({96'd0, tmin})) return 0;
    if (tabs > wide_t'({96'd0, tmax})) return 0;
    aoff = off < 0 ? -off : off;
    if (aoff > wide_t'({96'd0, maxoff})) return 0;
    t = tabs[31:0];
    return 1;
  endfunction

  task automatic predict_sample(in_item_t it);
    int unsigned h, r;
    logic signed [VALUE_BITS-1:0] vb, vc, va;
    bit cand, ok;
    logic [31:0] t;
    out_item_t o;
    h = half > MAX_HALF_WINDOW ? MAX_HALF_WINDOW : half;
    r = h == 0 ? 1 : h;
    ring_time[wr_pos] = it.sample_time;
    ring_val[wr_pos] = it.sample_value;
    wr_pos = (wr_pos + 1) % DEPTH;
    if (seen < 16'hFFFF) seen++;
    if (seen >= 2 * r + 1 && !(!backward && have_cross)) begin
      vb = ring_val[slot(r + 1)];
      vc = ring_val[slot(r)];
      va = ring_val[slot(r - 1)];
      cand = !backward ? (vb > lvl && vc < lvl && va < lvl)
                       : (vb > lvl && vc > lvl && va < lvl);
      if (cand) begin
        if (h == 0) begin
          t = ring_time[slot(r)];
          ok = 1;
        end else begin
          ok = fit_line(h, t);
        end
        if (ok) begin
          best_time = t;
          have_cross = 1;
        end
      end
    end
    if (it.last_sample) begin
      o.crossing_time = have_cross ? best_time : 32'd0;
      o.found = have_cross;
      crossing_q.push_back(o);
      seen = 0;
      best_time = 0;
      have_cross = 0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst) begin
      wr_pos = 0;
      seen = 0;
      best_time = 0;
      have_cross = 0;
      lvl = 0;
      half = 4;
      backward = 0;
      tmin = 0;
      tmax = 32'hFFFF_FFFF;
      maxoff = 1000;
      crossing_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL:      lvl = cfg_data[VALUE_BITS-1:0];
          CFG_HALF:       half = cfg_data[3:0];
          CFG_BACKWARD:   backward = cfg_data[0];
          CFG_TIME_MIN:   tmin = cfg_data;
          CFG_TIME_MAX:   tmax = cfg_data;
          CFG_MAX_OFFSET: maxoff = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) predict_sample(sample);
      if (result_valid && !result_stall) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: unexpected item, actual time %0d found %0b", $realtime,
                   result.crossing_time, result.found);
          errors++;
        end else begin
          exp_item = crossing_q.pop_front();
          if (exp_item.crossing_time !== result.crossing_time) begin
            $display("%0t: crossing_time expected %0d actual %0d", $realtime,
                     exp_item.crossing_time, result.crossing_time);
            errors++;
          end
          if (exp_item.found !== result.found) begin
            $display("%0t: found expected %0b actual %0b", $realtime,
                     exp_item.found, result.found);
            errors++;
          end
        end
      end
    end
    pending = crossing_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives waveforms and register writes into the block and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import lctf_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        sample_valid = 0;
  logic        sample_stall;
  in_item_t    sample = '0;
  logic        result_valid;
  logic        result_stall = 0;
  out_item_t   result;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_LEVEL;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          pending;

  bit          no_idle = 0;
  bit          hold_long = 0;
  int          cur_level = 0;
  int          sent = 0;

  always #1 clk = ~clk;

  level_crossing_time_fit dut (.*);

  lctf_checker chk (.*);

  initial begin
    #10ms;
    $display("tb: errors");
    $finish;
  end

  // receiver: random stall per item, one long hold on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        result_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_long = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(19, 0);
        if (n > 0) begin
          result_stall <= 1;
          repeat (n) @(posedge clk);
        end
      end
      result_stall <= 0;
      do @(posedge clk); while (!result_valid);
    end
  end

  task automatic send_sample(logic [31:0] t, int v, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(19, 0);
    if (gap > 0) begin
      sample_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    sample.sample_time <= t;
    sample.sample_value <= v[15:0];
    sample.last_sample <= last;
    sample_valid <= 1;
    do @(posedge clk); while (sample_stall);
    sent++;
  endtask

  task automatic drain();
    sample_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic int clamp(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // mostly a falling edge through the level with random slope, noise and time step
  task automatic send_waveform(int len);
    logic [31:0] t;
    int k, slope, nz, step, mode;
    longint v;
    mode = $urandom_range(9, 0);
    t = ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(100000, 0);
    k = $urandom_range(len - 1, 0);
    slope = $urandom_range(4000, 1);
    nz = $urandom_range(3, 0) == 0 ? $urandom_range(2000, 0) : 0;
    step = $urandom_range(500, 1);
    for (int i = 0; i < len; i++) begin
      if (mode == 0) v = $signed($urandom_range(65535, 0)) - 32768;
      else v = cur_level + longint'(k - i) * slope + $signed($urandom_range(2 * nz, 0)) - nz;
      send_sample(t, clamp(v), i == len - 1);
      if (mode == 1) t = $urandom;
      else t = t + step + $urandom_range(step / 4, 0);
    end
  endtask

  task automatic setup(int lv, int hw, bit bk, logic [31:0] lo, logic [31:0] hi,
                       logic [31:0] mo);
    write_reg(CFG_LEVEL, lv);
    write_reg(CFG_HALF, hw);
    write_reg(CFG_BACKWARD, 32'(bk));
    write_reg(CFG_TIME_MIN, lo);
    write_reg(CFG_TIME_MAX, hi);
    write_reg(CFG_MAX_OFFSET, mo);
    cur_level = lv;
  endtask

  initial begin
    int lv;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of fields, single sample and short waveforms
    send_sample(32'h0, 32767, 0);
    send_sample(32'd10, -32768, 0);
    send_sample(32'd20, -32768, 0);
    send_sample(32'hFFFF_FFFF, 0, 1);
    send_sample(32'd5, 0, 1);
    drain();
    setup(0, 0, 0, 0, 32'hFFFF_FFFF, 1000);
    send_sample(32'd1, 100, 0);
    send_sample(32'd2, -100, 0);
    send_sample(32'd3, -100, 1);
    drain();
    setup(0, 0, 1, 0, 32'hFFFF_FFFF, 0);
    send_sample(32'd1, 100, 0);
    send_sample(32'd2, 100, 0);
    send_sample(32'd3, -100, 1);
    drain();
    setup(-32768, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFF0, 32767, 0);
    send_sample(32'hFFFF_FFF8, -32768, 0);
    send_sample(32'hFFFF_FFFF, -32768, 1);
    drain();
    setup(32767, 15, 0, 0, 0, 0);
    send_waveform(20);
    drain();
    setup(0, 8, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1000);
    send_waveform(20);
    drain();

    // random phases
    for (int ph = 0; sent < 470; ph++) begin
      lv = $urandom_range(3, 0) == 0 ? $signed($urandom_range(65535, 0)) - 32768
                                     : $signed($urandom_range(2000, 0)) - 1000;
      case (ph % 4)
        0: setup(lv, $urandom_range(8, 1), $urandom_range(1, 0), 0, 32'hFFFF_FFFF,
                 $urandom_range(2000, 0));
        1: setup(lv, $urandom_range(15, 0), $urandom_range(1, 0), $urandom_range(50000, 0),
                 32'hFFFF_FFFF - $urandom_range(1000, 0), $urandom);
        2: setup(lv, $urandom_range(2, 0), $urandom_range(1, 0), 0, $urandom, 32'hFFFF_FFFF);
        default: setup(lv, 8, $urandom_range(1, 0), 0, 32'hFFFF_FFFF, 1000);
      endcase
      no_idle = (ph % 5 == 3);
      if (ph == 2) hold_long = 1;
      repeat ($urandom_range(4, 1)) send_waveform($urandom_range(24, 1));
      drain();
    end

    no_idle = 0;
    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lctf_pkg.sv
rtl/lctf_cell.sv
rtl/lctf_mul.sv
rtl/lctf_div.sv
rtl/level_crossing_time_fit.sv
tb/lctf_checker.sv
tb/tb.sv
